// ===== rtl/sadm_pkg.sv =====
package sadm_pkg;

	localparam int IMAGE_BYTES = 4194304;
	localparam int IMG_AW      = $clog2(IMAGE_BYTES);
	localparam int IMG_ROWS    = (IMAGE_BYTES + 3) / 4;
	localparam int IMG_RW      = $clog2(IMG_ROWS);

	localparam int RAM_BYTES = 688128;
	localparam int RAM_AW    = $clog2(RAM_BYTES);
	localparam int RAM_ROWS  = RAM_BYTES / 4;
	localparam int RAM_RW    = $clog2(RAM_ROWS);

	localparam int LEN_W = 23;
	localparam int WIN_W = 22;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FETCH = 2'd2;
	localparam logic [1:0] OP_LOAD  = 2'd3;

	localparam logic [1:0] K_ROM    = 2'd0;
	localparam logic [1:0] K_RAM    = 2'd1;
	localparam logic [1:0] K_FLASH  = 2'd2;
	localparam logic [1:0] K_PERIPH = 2'd3;

	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_ONES = 2'd1;
	localparam logic [1:0] SEL_RAM  = 2'd2;
	localparam logic [1:0] SEL_IMG  = 2'd3;

	localparam int NREG   = 12;
	localparam int REG_IW = $clog2(NREG);

	localparam logic [31:0] REG_BASE [NREG] = '{
		32'h4000_0000, 32'h3FF9_0000, 32'h4007_0000, 32'h400A_0000,
		32'h3FFE_0000, 32'h3FFA_E000, 32'h3FF8_0000, 32'h400C_0000,
		32'h5000_0000, 32'h3F40_0000, 32'h400D_0000, 32'h3FF0_0000
	};
	localparam logic [31:0] REG_SIZE [NREG] = '{
		32'h0006_0000, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000,
		32'h0002_0000, 32'h0003_2000, 32'h0000_2000, 32'h0000_2000,
		32'h0000_2000, 32'h0040_0000, 32'h0033_0000, 32'h0001_0000
	};
	localparam logic [1:0] REG_KIND [NREG] = '{
		K_ROM, K_ROM, K_RAM, K_RAM, K_RAM, K_RAM,
		K_RAM, K_RAM, K_RAM, K_FLASH, K_FLASH, K_PERIPH
	};
	localparam logic [31:0] REG_STORE [NREG] = '{
		32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000,
		32'h0005_0000, 32'h0007_0000, 32'h000A_2000, 32'h000A_4000,
		32'h000A_6000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
	};

	localparam logic [31:0] IROM_LO = 32'h400D_0000;
	localparam logic [31:0] IROM_HI = 32'h4040_0000;
	localparam logic [31:0] DROM_LO = 32'h3F40_0000;
	localparam logic [31:0] DROM_HI = 32'h3F80_0000;
	localparam logic [31:0] BOOT_LO = 32'h4000_0000;
	localparam logic [31:0] BOOT_HI = 32'h4007_0000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        fetch_fault;
		logic        periph_request;
		logic        periph_write;
		logic [31:0] periph_address;
		logic [31:0] periph_data;
	} rsp_t;

	typedef struct packed {
		logic [1:0]        sel;
		logic              ram_wr;
		logic              img_wr;
		logic [RAM_RW-1:0] ram_row;
		logic [IMG_RW-1:0] img_row;
		logic [1:0]        lane;
		logic              fault;
		logic              preq;
		logic              pwr;
		logic [31:0]       paddr;
		logic [31:0]       pdata;
	} dec_t;

	// byte i of the word lands in lane (k + i) mod 4
	function automatic logic [31:0] lanes_from_word(input logic [31:0] w, input logic [1:0] k);
		logic [31:0] l;
		logic [1:0]  i;
		l = '0;
		for (int j = 0; j < 4; j++) begin
			i = 2'(j) - k;
			l[8*j +: 8] = w[8*i +: 8];
		end
		return l;
	endfunction

	function automatic logic [31:0] word_from_lanes(input logic [31:0] l, input logic [1:0] k);
		logic [31:0] w;
		logic [1:0]  j;
		w = '0;
		for (int i = 0; i < 4; i++) begin
			j = 2'(i) + k;
			w[8*i +: 8] = l[8*j +: 8];
		end
		return w;
	endfunction

endpackage

// ===== rtl/soc_address_map_decoder_unit.sv =====
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_data (image_length)
// req      in         req_valid/req_stall  req (sadm_pkg::req_t)
// rsp      out        rsp_valid/rsp_stall  rsp (sadm_pkg::rsp_t)
//
// One transaction per cycle while req_stall is low; each result is registered from stage 1.
// The lane-split RAM and image memories are read into a register as a request is taken.
// After reset the RAM is zero filled, one row per cycle; req_stall is high until done.
// rsp is held in an output register; one further request is held in stage 1 behind it,
// and req_stall rises only in the RAM clear or when both are full and rsp_stall is high.
module soc_address_map_decoder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sadm_pkg::LEN_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  sadm_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output sadm_pkg::rsp_t             rsp
);
	import sadm_pkg::*;

	logic [LEN_W-1:0] image_length_q;
	dec_t             dec;
	dec_t             dec_s1;
	logic             s1_valid_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             accept;
	logic             advance;
	logic             clearing;
	logic [31:0]      ram_rdata;
	logic [31:0]      img_rdata;
	logic [31:0]      rd_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			image_length_q <= cfg_data;
		end
	end

	sadm_decode u_decode (
		.req          (req),
		.image_length (image_length_q),
		.dec          (dec)
	);

	assign advance   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing || (s1_valid_q && !advance);
	assign accept    = req_valid && !req_stall;

	sadm_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && (dec.sel == SEL_RAM)),
		.wr_en    (accept && dec.ram_wr),
		.row      (dec.ram_row),
		.lane     (dec.lane),
		.wdata    (req.write_data),
		.clearing (clearing),
		.rdata    (ram_rdata)
	);

	sadm_image u_image (
		.clk   (clk),
		.rd_en (accept && (dec.sel == SEL_IMG)),
		.wr_en (accept && dec.img_wr),
		.row   (dec.img_row),
		.lane  (dec.lane),
		.wbyte (req.write_data[7:0]),
		.rdata (img_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
	end

	always_comb begin
		case (dec_s1.sel)
			SEL_ONES: rd_word = 32'hFFFF_FFFF;
			SEL_RAM:  rd_word = ram_rdata;
			SEL_IMG:  rd_word = img_rdata;
			default:  rd_word = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data      <= rd_word;
			rsp_q.fetch_fault    <= dec_s1.fault;
			rsp_q.periph_request <= dec_s1.preq;
			rsp_q.periph_write   <= dec_s1.pwr;
			rsp_q.periph_address <= dec_s1.paddr;
			rsp_q.periph_data    <= dec_s1.pdata;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fault_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.fetch_fault |-> rsp_q.read_data == 32'd0)
		else $error("fetch fault with nonzero read data");

	a_periph_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.periph_request |->
			!rsp_q.periph_write && rsp_q.periph_address == 32'd0 &&
			rsp_q.periph_data == 32'd0)
		else $error("peripheral fields set without a request");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(dec_s1))
		else $error("stage 1 overwritten while blocked");

	a_rsp_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(s1_valid_q))
		else $error("response without a stage 1 transaction");

	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> !s1_valid_q || $past(s1_valid_q))
		else $error("transaction taken during RAM clear");

endmodule

// ===== rtl/sadm_decode.sv =====
module sadm_decode (
	input  sadm_pkg::req_t              req,
	input  logic [sadm_pkg::LEN_W-1:0]  image_length,
	output sadm_pkg::dec_t              dec
);
	import sadm_pkg::*;

	logic              found;
	logic [REG_IW-1:0] idx;
	logic [31:0]       off;
	logic [31:0]       room;
	logic              fits;
	logic [RAM_AW-1:0] ram_ptr;
	logic [LEN_W-1:0]  len_eff;
	logic              irom_win;
	logic              drom_win;
	logic              boot_win;
	logic [WIN_W-1:0]  irom_off;
	logic [WIN_W-1:0]  drom_off;
	logic              irom_ok;
	logic              drom_ok;
	logic              data_en;
	logic              data_wr;

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = 0; i < NREG; i++) begin
			if (!found && ((req.address - REG_BASE[i]) < REG_SIZE[i])) begin
				found = 1'b1;
				idx   = REG_IW'(i);
			end
		end
	end

	assign off     = req.address - REG_BASE[idx];
	assign room    = REG_SIZE[idx] - off;
	assign fits    = room >= 32'd4;
	assign ram_ptr = RAM_AW'(REG_STORE[idx] + off);

	assign len_eff = (image_length > LEN_W'(IMAGE_BYTES)) ? LEN_W'(IMAGE_BYTES) : image_length;

	assign irom_win = (req.address >= IROM_LO) && (req.address < IROM_HI);
	assign drom_win = (req.address >= DROM_LO) && (req.address < DROM_HI);
	assign boot_win = (req.address >= BOOT_LO) && (req.address < BOOT_HI);
	assign irom_off = WIN_W'(req.address - IROM_LO);
	assign drom_off = WIN_W'(req.address - DROM_LO);
	assign irom_ok  = (25'(irom_off) + 25'd4) <= 25'(len_eff);
	assign drom_ok  = (25'(drom_off) + 25'd4) <= 25'(len_eff);

	always_comb begin
		dec         = '0;
		data_en     = 1'b0;
		data_wr     = 1'b0;
		dec.lane    = ram_ptr[1:0];
		dec.ram_row = ram_ptr[RAM_AW-1:2];
		case (req.opcode)
			OP_READ: begin
				data_en = 1'b1;
			end
			OP_WRITE: begin
				data_en = 1'b1;
				data_wr = 1'b1;
			end
			OP_LOAD: begin
				dec.img_wr  = req.address < 32'(IMAGE_BYTES);
				dec.lane    = req.address[1:0];
				dec.img_row = req.address[IMG_AW-1:2];
			end
			OP_FETCH: begin
				if (irom_win) begin
					if (irom_ok) begin
						dec.sel     = SEL_IMG;
						dec.lane    = irom_off[1:0];
						dec.img_row = irom_off[IMG_AW-1:2];
					end else begin
						dec.fault = 1'b1;
					end
				end else if (drom_win && drom_ok) begin
					dec.sel     = SEL_IMG;
					dec.lane    = drom_off[1:0];
					dec.img_row = drom_off[IMG_AW-1:2];
				end else if (!boot_win) begin
					data_en = 1'b1;
				end
			end
			default: begin
				data_en = 1'b0;
			end
		endcase

		if (data_en && found) begin
			if (REG_KIND[idx] == K_PERIPH) begin
				dec.preq  = 1'b1;
				dec.pwr   = data_wr;
				dec.paddr = req.address;
				dec.pdata = data_wr ? req.write_data : 32'd0;
			end else if (fits) begin
				if (REG_KIND[idx] == K_RAM) begin
					if (data_wr) begin
						dec.ram_wr = 1'b1;
					end else begin
						dec.sel = SEL_RAM;
					end
				end else if (!data_wr) begin
					dec.sel = SEL_ONES;
				end
			end
		end
	end

endmodule

// ===== rtl/sadm_ram.sv =====
module sadm_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic                        wr_en,
	input  logic [sadm_pkg::RAM_RW-1:0] row,
	input  logic [1:0]                  lane,
	input  logic [31:0]                 wdata,
	output logic                        clearing,
	output logic [31:0]                 rdata
);
	import sadm_pkg::*;

	logic              clearing_q;
	logic [RAM_RW-1:0] clr_row_q;
	logic [31:0]       wlanes;
	logic [1:0]        lane_q;
	logic [7:0]        rd_q [4];
	logic [31:0]       rlanes;

	assign clearing = clearing_q;
	assign wlanes   = lanes_from_word(wdata, lane);

	// zero fill after reset, one row of all four lanes per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + RAM_RW'(1);
			if (clr_row_q == RAM_RW'(RAM_ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic [7:0]        mem [RAM_ROWS];
		logic [RAM_RW-1:0] row_j;
		logic [RAM_RW-1:0] wrow;

		assign row_j = (2'(j) < lane) ? row + RAM_RW'(1) : row;
		assign wrow  = clearing_q ? clr_row_q : row_j;

		always_ff @(posedge clk) begin
			if (clearing_q || wr_en) begin
				mem[wrow] <= clearing_q ? 8'h00 : wlanes[8*j +: 8];
			end
			if (rd_en) begin
				rd_q[j] <= mem[row_j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			lane_q <= lane;
		end
	end

	assign rlanes = {rd_q[3], rd_q[2], rd_q[1], rd_q[0]};
	assign rdata  = word_from_lanes(rlanes, lane_q);

endmodule

// ===== rtl/sadm_image.sv =====
module sadm_image (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic                        wr_en,
	input  logic [sadm_pkg::IMG_RW-1:0] row,
	input  logic [1:0]                  lane,
	input  logic [7:0]                  wbyte,
	output logic [31:0]                 rdata
);
	import sadm_pkg::*;

	logic [31:0] wlanes;
	logic [1:0]  lane_q;
	logic [7:0]  rd_q [4];
	logic [31:0] rlanes;

	assign wlanes = lanes_from_word({24'd0, wbyte}, lane);

	for (genvar j = 0; j < 4; j++) begin : g_lane
		logic [7:0]        mem [IMG_ROWS];
		logic [IMG_RW-1:0] row_j;

		assign row_j = (2'(j) < lane) ? row + IMG_RW'(1) : row;

		// a byte load touches only its own lane
		always_ff @(posedge clk) begin
			if (wr_en && (lane == 2'(j))) begin
				mem[row] <= wlanes[8*j +: 8];
			end
			if (rd_en) begin
				rd_q[j] <= mem[row_j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			lane_q <= lane;
		end
	end

	assign rlanes = {rd_q[3], rd_q[2], rd_q[1], rd_q[0]};
	assign rdata  = word_from_lanes(rlanes, lane_q);

endmodule

// ===== tb/sv/soc_address_map_decoder_unit_test.sv =====
module soc_address_map_decoder_unit_test;
	import sadm_pkg::*;

	localparam int unsigned RAM_TOTAL   = 688128;
	localparam int unsigned IMG_TOTAL   = 4194304;
	localparam int          NREGIONS    = 12;
	localparam int          PHASE_ITEMS = 160;
	localparam int          CYCLE_LIMIT = 1500000;

	localparam logic [31:0] IMEM_LO    = 32'h400D_0000;
	localparam logic [31:0] IMEM_HI    = 32'h4040_0000;
	localparam logic [31:0] DMEM_LO    = 32'h3F40_0000;
	localparam logic [31:0] DMEM_HI    = 32'h3F80_0000;
	localparam logic [31:0] BOOTWIN_LO = 32'h4000_0000;
	localparam logic [31:0] BOOTWIN_HI = 32'h4007_0000;

	localparam rsp_t NIL       = '0;
	localparam rsp_t ONES_WORD = '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0};

	typedef struct packed {
		req_t item;
		logic typed;
		rsp_t want;
	} step_t;

	// image_length is 8 while this runs
	localparam step_t OPENING [25] = '{
		'{'{OP_READ,  32'h4007_0000, 32'h0}, 1'b1, NIL},
		'{'{OP_WRITE, 32'h4007_0000, 32'hA5A5_5A5F}, 1'b1, NIL},
		'{'{OP_READ,  32'h4007_0001, 32'h0}, 1'b0, NIL},
		'{'{OP_WRITE, 32'h5000_1FFC, 32'hFFFF_FFFF}, 1'b1, NIL},
		'{'{OP_READ,  32'h5000_1FFD, 32'h0}, 1'b1, NIL},
		'{'{OP_READ,  32'h5000_1FFC, 32'h0}, 1'b1, ONES_WORD},
		'{'{OP_READ,  32'h4000_0000, 32'h0}, 1'b1, ONES_WORD},
		'{'{OP_WRITE, 32'h3FF9_0000, 32'hFFFF_FFFF}, 1'b1, NIL},
		'{'{OP_READ,  32'h3FF9_0000, 32'h0}, 1'b1, ONES_WORD},
		'{'{OP_READ,  32'h3FF9_FFFE, 32'h0}, 1'b1, NIL},
		'{'{OP_READ,  32'h0000_0000, 32'h0}, 1'b1, NIL},
		'{'{OP_READ,  32'hFFFF_FFFF, 32'h0}, 1'b1, NIL},
		'{'{OP_WRITE, 32'h3FF0_0010, 32'h1234_5678}, 1'b1,
			'{32'h0, 1'b0, 1'b1, 1'b1, 32'h3FF0_0010, 32'h1234_5678}},
		'{'{OP_READ,  32'h3FF0_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{32'h0, 1'b0, 1'b1, 1'b0, 32'h3FF0_FFFF, 32'h0}},
		'{'{OP_LOAD,  32'h0000_0000, 32'h0000_0011}, 1'b1, NIL},
		'{'{OP_LOAD,  32'h0000_0001, 32'hFFFF_FF22}, 1'b1, NIL},
		'{'{OP_LOAD,  32'h0000_0002, 32'h0000_0033}, 1'b1, NIL},
		'{'{OP_LOAD,  32'h0000_0003, 32'h0000_0044}, 1'b1, NIL},
		'{'{OP_LOAD,  32'hFFFF_FFFF, 32'h0000_00FF}, 1'b1, NIL},
		'{'{OP_FETCH, 32'h400D_0000, 32'h0}, 1'b1, '{32'h4433_2211, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_FETCH, 32'h3F40_0000, 32'h0}, 1'b1, '{32'h4433_2211, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_FETCH, 32'h400D_0006, 32'h0}, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0}},
		'{'{OP_FETCH, 32'h3F40_0005, 32'h0}, 1'b1, ONES_WORD},
		'{'{OP_FETCH, 32'h4000_0010, 32'h0}, 1'b1, NIL},
		'{'{OP_FETCH, 32'h3FF0_0004, 32'h0}, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 32'h3FF0_0004, 32'h0}}
	};

	localparam logic [22:0] LEN_STEPS [9] = '{
		23'd0, 23'd3, 23'd4, 23'd256, 23'd2051, 23'h33_0000, 23'h40_0000, 23'h7F_FFFF, 23'd100
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [22:0] cfg_data;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	bit [7:0]    ram_shadow [RAM_TOTAL];
	bit [7:0]    image_shadow [IMG_TOTAL];
	bit          image_written [IMG_TOTAL];
	logic [22:0] image_len_set;
	bit          unwritten_read;
	rsp_t        replies_due [$];

	bit calm;
	int err_count;
	int cycle_count = 0;
	int stall_left = 0;
	int accesses_done;
	int loads_done;
	int replies_checked;
	int faults_seen;
	int periph_seen;
	int len_settings;

	soc_address_map_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				replies_due.size());
			$display("soc_address_map_decoder_unit_test NOT OK");
			$finish;
		end
	end

	// ---------------- address map and bus model ----------------

	function automatic void region_entry(input int i, output logic [31:0] base,
		output logic [31:0] span, output logic [1:0] kind, output logic [31:0] store);
		store = 32'h0;
		case (i)
			0: begin base = 32'h4000_0000; span = 32'h0006_0000; kind = K_ROM; end
			1: begin base = 32'h3FF9_0000; span = 32'h0001_0000; kind = K_ROM; end
			2: begin base = 32'h4007_0000; span = 32'h0003_0000; kind = K_RAM; end
			3: begin
				base = 32'h400A_0000; span = 32'h0002_0000; kind = K_RAM; store = 32'h3_0000;
			end
			4: begin
				base = 32'h3FFE_0000; span = 32'h0002_0000; kind = K_RAM; store = 32'h5_0000;
			end
			5: begin
				base = 32'h3FFA_E000; span = 32'h0003_2000; kind = K_RAM; store = 32'h7_0000;
			end
			6: begin
				base = 32'h3FF8_0000; span = 32'h0000_2000; kind = K_RAM; store = 32'hA_2000;
			end
			7: begin
				base = 32'h400C_0000; span = 32'h0000_2000; kind = K_RAM; store = 32'hA_4000;
			end
			8: begin
				base = 32'h5000_0000; span = 32'h0000_2000; kind = K_RAM; store = 32'hA_6000;
			end
			9: begin base = 32'h3F40_0000; span = 32'h0040_0000; kind = K_FLASH; end
			10: begin base = 32'h400D_0000; span = 32'h0033_0000; kind = K_FLASH; end
			11: begin base = 32'h3FF0_0000; span = 32'h0001_0000; kind = K_PERIPH; end
			default: begin base = 32'h0; span = 32'h0; kind = K_ROM; end
		endcase
	endfunction

	function automatic int region_of(input logic [31:0] a);
		logic [31:0] base, span, store;
		logic [1:0]  kind;
		int          hit;
		hit = -1;
		for (int i = NREGIONS - 1; i >= 0; i--) begin
			region_entry(i, base, span, kind, store);
			if (a - base < span)
				hit = i;
		end
		return hit;
	endfunction

	function automatic logic [31:0] image_limit();
		return (image_len_set > IMG_TOTAL) ? IMG_TOTAL : 32'(image_len_set);
	endfunction

	function automatic rsp_t bus_access(input logic [31:0] a, input bit wr,
		input logic [31:0] wd);
		rsp_t        o;
		logic [31:0] base, span, store, off, p;
		logic [1:0]  kind;
		int          r;
		o = '0;
		r = region_of(a);
		if (r >= 0) begin
			region_entry(r, base, span, kind, store);
			off = a - base;
			if (kind == K_PERIPH) begin
				o.periph_request = 1'b1;
				o.periph_write   = wr;
				o.periph_address = a;
				o.periph_data    = wr ? wd : 32'h0;
			end else if (span - off >= 4) begin
				if (kind != K_RAM) begin
					if (!wr)
						o.read_data = 32'hFFFF_FFFF;
				end else begin
					p = store + off;
					if (p <= RAM_TOTAL - 4) begin
						for (int b = 0; b < 4; b++) begin
							if (wr)
								ram_shadow[p + b] = wd[8*b +: 8];
							else
								o.read_data[8*b +: 8] = ram_shadow[p + b];
						end
					end
				end
			end
		end
		return o;
	endfunction

	function automatic bit image_word(input logic [31:0] off, output logic [31:0] w);
		logic [31:0] len;
		bit          ok;
		len = image_limit();
		w = '0;
		ok = !(off >= len || len - off <= 3);
		if (ok) begin
			for (int b = 0; b < 4; b++) begin
				if (!image_written[off + b])
					unwritten_read = 1'b1;
				w[8*b +: 8] = image_shadow[off + b];
			end
		end
		return ok;
	endfunction

	// sets unwritten_read when the access would see an image byte never loaded
	function automatic void decode_access(input req_t r, output rsp_t o);
		logic [31:0] w;
		unwritten_read = 1'b0;
		o = '0;
		case (r.opcode)
			OP_READ:  o = bus_access(r.address, 1'b0, 32'h0);
			OP_WRITE: o = bus_access(r.address, 1'b1, r.write_data);
			OP_LOAD: begin
				if (r.address < IMG_TOTAL) begin
					image_shadow[r.address]  = r.write_data[7:0];
					image_written[r.address] = 1'b1;
				end
			end
			default: begin
				if (r.address >= IMEM_LO && r.address < IMEM_HI) begin
					if (image_word(r.address - IMEM_LO, w))
						o.read_data = w;
					else
						o.fetch_fault = 1'b1;
				end else if (r.address >= DMEM_LO && r.address < DMEM_HI &&
					image_word(r.address - DMEM_LO, w)) begin
					o.read_data = w;
				end else if (!(r.address >= BOOTWIN_LO && r.address < BOOTWIN_HI)) begin
					o = bus_access(r.address, 1'b0, 32'h0);
				end
			end
		endcase
	endfunction

	// ---------------- stimulus ----------------

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [31:0] pick_data_address();
		logic [31:0] base, span, store, a;
		logic [1:0]  kind;
		case ($urandom_range(0, 9))
			1, 2, 3, 4: begin
				region_entry($urandom_range(2, 8), base, span, kind, store);
				case ($urandom_range(0, 2))
					0: a = base + $urandom_range(0, 63);
					1: a = base + span - 8 + $urandom_range(0, 7);
					default: a = base + $urandom_range(0, span - 1);
				endcase
			end
			5, 6: begin
				region_entry($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(9, 10),
					base, span, kind, store);
				a = $urandom_range(0, 1) ? base + span - 6 + $urandom_range(0, 5)
					: base + $urandom_range(0, span - 1);
			end
			7: a = 32'h3FF0_0000 + $urandom_range(0, 32'hFFFF);
			8: begin
				region_entry($urandom_range(0, NREGIONS - 1), base, span, kind, store);
				a = $urandom_range(0, 1) ? base - $urandom_range(1, 4)
					: base + span - 4 + $urandom_range(0, 7);
			end
			default: a = $urandom;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] pick_image_offset();
		int off;
		case ($urandom_range(0, 4))
			0, 1: off = $urandom_range(0, 2100);
			2: begin
				off = int'(image_limit()) - 6 + $urandom_range(0, 8);
				if (off < 0)
					off = 0;
			end
			3: off = ($urandom_range(0, 1) ? 32'h32_FFF8 : 32'h3F_FFF8) + $urandom_range(0, 7);
			default: off = $urandom_range(0, 32'h3F_FFFF);
		endcase
		return off;
	endfunction

	function automatic req_t pick_fetch();
		req_t r;
		rsp_t probe;
		bit   done;
		r.opcode     = OP_FETCH;
		r.write_data = $urandom;
		r.address    = BOOTWIN_LO + $urandom_range(0, 32'h6_FFFF);
		done = 1'b0;
		for (int t = 0; t < 6 && !done; t++) begin
			case ($urandom_range(0, 4))
				0, 1: r.address = IMEM_LO + pick_image_offset();
				2: r.address = DMEM_LO + pick_image_offset();
				3: r.address = $urandom_range(0, 1) ? BOOTWIN_LO + $urandom_range(0, 32'h6_FFFF)
					: BOOTWIN_HI - 4 + $urandom_range(0, 7);
				default: r.address = pick_data_address();
			endcase
			decode_access(r, probe);
			done = !unwritten_read;
		end
		if (!done)
			r.address = BOOTWIN_LO + $urandom_range(0, 32'h6_FFFF);
		return r;
	endfunction

	function automatic req_t pick_access();
		req_t r;
		int   off;
		r.write_data = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: begin r.opcode = OP_READ; r.address = pick_data_address(); end
			3, 4, 5: begin r.opcode = OP_WRITE; r.address = pick_data_address(); end
			6, 7, 8: r = pick_fetch();
			default: begin
				r.opcode = OP_LOAD;
				case ($urandom_range(0, 3))
					0: off = $urandom_range(0, 2100);
					1: off = IMG_TOTAL - 4 + $urandom_range(0, 7);
					2: begin
						off = int'(image_limit()) - 8 + $urandom_range(0, 15);
						if (off < 0)
							off = 0;
					end
					default: off = $urandom;
				endcase
				r.address = off;
			end
		endcase
		return r;
	endfunction

	task automatic issue(input req_t item, input logic typed, input rsp_t want);
		rsp_t pred;
		int   gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		decode_access(item, pred);
		replies_due.insert(replies_due.size(), typed ? want : pred);
		faults_seen += pred.fetch_fault;
		periph_seen += pred.periph_request;
		if (item.opcode == OP_LOAD)
			loads_done++;
		if (!(item.opcode == OP_LOAD && item.address >= IMG_TOTAL)) begin
			accesses_done++;
			if (accesses_done % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
		end
	endtask

	task automatic load_byte(input int off);
		issue('{OP_LOAD, 32'(off), 32'($urandom)}, 1'b0, NIL);
	endtask

	// a short image burst followed by a fetch of a word inside it
	task automatic run_program();
		int   off, n;
		req_t r;
		if ($urandom_range(0, 1))
			off = $urandom_range(0, 2048);
		else
			off = int'(image_limit()) - 12 + $urandom_range(0, 8);
		if (off < 0)
			off = 0;
		if (off > IMG_TOTAL - 16)
			off = IMG_TOTAL - 16;
		n = $urandom_range(4, 12);
		for (int i = 0; i < n; i++)
			load_byte(off + i);
		r.opcode     = OP_FETCH;
		r.address    = ($urandom_range(0, 1) ? IMEM_LO : DMEM_LO) + off + $urandom_range(0, n - 4);
		r.write_data = $urandom;
		issue(r, 1'b0, NIL);
	endtask

	task automatic set_image_length(input logic [22:0] v);
		req_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		image_len_set = v;
		len_settings++;
	endtask

	// ---------------- response side ----------------

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("[%0d] reply %0d: %s", cycle_count, replies_checked, msg);
	endtask

	task automatic check_reply(input rsp_t got);
		rsp_t want;
		if (replies_due.size() == 0) begin
			report_mismatch($sformatf("unexpected transaction %h", got));
		end else begin
			want = replies_due.pop_front();
			if (got.read_data !== want.read_data)
				report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
			if (got.fetch_fault !== want.fetch_fault)
				report_mismatch($sformatf("fetch_fault %b, want %b", got.fetch_fault,
					want.fetch_fault));
			if (got.periph_request !== want.periph_request)
				report_mismatch($sformatf("periph_request %b, want %b", got.periph_request,
					want.periph_request));
			if (got.periph_write !== want.periph_write)
				report_mismatch($sformatf("periph_write %b, want %b", got.periph_write,
					want.periph_write));
			if (got.periph_address !== want.periph_address)
				report_mismatch($sformatf("periph_address %h, want %h", got.periph_address,
					want.periph_address));
			if (got.periph_data !== want.periph_data)
				report_mismatch($sformatf("periph_data %h, want %h", got.periph_data,
					want.periph_data));
		end
		replies_checked++;
	endtask

	always @(posedge clk) begin : take_reply
		int hold;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				check_reply(rsp);
				hold = draw_wait();
				stall_left <= hold;
				rsp_stall  <= (hold != 0);
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else if (stall_left == 1) begin
				stall_left <= 0;
				rsp_stall  <= 1'b0;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		logic [22:0] next_len;
		int          target;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		req_valid     = 1'b0;
		req           = '0;
		image_len_set = '0;
		calm          = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_image_length(23'd8);
		for (int i = 0; i < 25; i++)
			issue(OPENING[i].item, OPENING[i].typed, OPENING[i].want);

		for (int i = 4; i < 256; i++)
			load_byte(i);
		for (int i = 0; i < 8; i++) begin
			load_byte(32'h32_FFF8 + i);
			load_byte(32'h3F_FFF8 + i);
		end

		for (int ph = 0; ph < 10; ph++) begin
			next_len = (ph == 9) ? 23'($urandom_range(0, 23'h7F_FFFF)) : LEN_STEPS[ph];
			set_image_length(next_len);
			target = accesses_done + PHASE_ITEMS;
			while (accesses_done < target) begin
				if ($urandom_range(0, 4) == 0)
					run_program();
				else
					issue(pick_access(), 1'b0, NIL);
			end
		end

		req_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d accesses (%0d image loads) across %0d image length settings",
			accesses_done, loads_done, len_settings);
		$display("%0d replies checked: %0d fetch faults, %0d peripheral requests, %0d errors",
			replies_checked, faults_seen, periph_seen, err_count);
		if (err_count == 0)
			$display("soc_address_map_decoder_unit_test OK");
		else
			$display("soc_address_map_decoder_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== soc_address_map_decoder_unit.f =====
rtl/sadm_pkg.sv
rtl/sadm_decode.sv
rtl/sadm_ram.sv
rtl/sadm_image.sv
rtl/soc_address_map_decoder_unit.sv
tb/sv/soc_address_map_decoder_unit_test.sv
